/* hdl/bf3_pkg.sv */
// Shared types, constants and the range-weight fraction table for the 3x3 bilateral filter.
package bf3_pkg;

    localparam int CH_W      = 8;
    localparam int PIX_W     = 24;
    localparam int D2_W      = 18;
    localparam int COEF_W    = 32;
    localparam int SPW_W     = 16;
    localparam int TAB_W     = 33;
    localparam int FIDX_W    = 6;
    localparam int NSH_W     = 6;
    localparam int N_LANES   = 9;
    localparam int N_CH      = 3;
    localparam int CFG_IDX_W = 2;
    localparam int N_STAGES  = 16;
    localparam int LANE_ST   = 5;
    localparam int ACC_ST    = 3;
    localparam int DIV_ST    = 8;
    localparam int N_RANGE_MAX = 40;

    // 2^(-1/64) in Q0.32, truncated
    localparam logic [31:0] POW2_NEG_64TH = 32'd4248701964;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPW_CENTER = 2'd0,
        CFG_SPW_EDGE   = 2'd1,
        CFG_SPW_CORNER = 2'd2,
        CFG_RANGE_COEF = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        POS_CENTER = 2'd0,
        POS_EDGE   = 2'd1,
        POS_CORNER = 2'd2
    } t_pos_kind;

    // window order: C, NW, N, NE, W, E, SW, S, SE
    typedef t_pos_kind t_lane_kinds [N_LANES];
    localparam t_lane_kinds LANE_KIND = '{POS_CENTER, POS_CORNER, POS_EDGE, POS_CORNER,
                                          POS_EDGE, POS_EDGE, POS_CORNER, POS_EDGE,
                                          POS_CORNER};

    typedef logic [TAB_W-1:0] t_frac_tab [64];

    function automatic t_frac_tab build_frac_tab();
        t_frac_tab   tab;
        logic [65:0] t;
        t = 66'd1 << 32;
        for (int k = 0; k < 64; k++) begin
            tab[k] = t[TAB_W-1:0];
            t = (t * {34'd0, POW2_NEG_64TH}) >> 32;
        end
        return tab;
    endfunction

    localparam t_frac_tab FRAC_TAB = build_frac_tab();

endpackage

/* hdl/bf3_lane.sv */
// One window position: color distance, range exponent, range weight and position weight.
module bf3_lane #(
    parameter int WFB = 15
) (
    input  logic                          i_clk,
    input  logic [bf3_pkg::LANE_ST-1:0]   i_en,
    input  logic [bf3_pkg::PIX_W-1:0]     i_pix,
    input  logic [bf3_pkg::PIX_W-1:0]     i_ctr,
    input  logic [bf3_pkg::COEF_W-1:0]    i_coef,
    input  logic [bf3_pkg::SPW_W-1:0]     i_spatial,
    output logic [bf3_pkg::SPW_W+WFB:0]   o_w,
    output logic [bf3_pkg::PIX_W-1:0]     o_pix
);
    localparam int R_W = WFB + 1;
    localparam int W_W = bf3_pkg::SPW_W + R_W;
    localparam int PP_W = bf3_pkg::D2_W + 16;
    localparam int E_W = bf3_pkg::D2_W + bf3_pkg::COEF_W;

    logic [bf3_pkg::PIX_W-1:0] r_pix [bf3_pkg::LANE_ST];
    logic [bf3_pkg::D2_W-1:0]  r_d2, n_d2;
    logic [PP_W-1:0]           r_plo, r_phi;
    logic [bf3_pkg::FIDX_W-1:0] r_f;
    logic [bf3_pkg::NSH_W-1:0]  r_n;
    logic                       r_zero;
    logic [E_W-1:0]             n_e;
    logic [R_W-1:0]             r_r, n_r, w_base;
    logic [W_W-1:0]             r_w;

    always_comb begin
        logic [7:0]  a, b, d;
        logic [15:0] sq [3];
        for (int c = 0; c < 3; c++) begin
            a = i_pix[c*8 +: 8];
            b = i_ctr[c*8 +: 8];
            d = (a >= b) ? a - b : b - a;
            sq[c] = d * d;
        end
        n_d2 = {2'd0, sq[0]} + {2'd0, sq[1]} + {2'd0, sq[2]};
    end

    assign n_e = {16'd0, r_plo} + {r_phi, 16'd0};
    assign w_base = bf3_pkg::FRAC_TAB[r_f][bf3_pkg::TAB_W-1 -: R_W];
    assign n_r = r_zero ? '0 : (w_base >> r_n);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_d2 <= n_d2;
            r_pix[0] <= i_pix;
        end
        // exponent split into two 18x16 partial products
        if (i_en[1]) begin
            r_plo <= r_d2 * i_coef[15:0];
            r_phi <= r_d2 * i_coef[31:16];
            r_pix[1] <= r_pix[0];
        end
        if (i_en[2]) begin
            r_zero <= (n_e[E_W-1:32] >= bf3_pkg::D2_W'(bf3_pkg::N_RANGE_MAX));
            r_n    <= n_e[32 +: bf3_pkg::NSH_W];
            r_f    <= n_e[31 -: bf3_pkg::FIDX_W];
            r_pix[2] <= r_pix[1];
        end
        if (i_en[3]) begin
            r_r <= n_r;
            r_pix[3] <= r_pix[2];
        end
        if (i_en[4]) begin
            r_w <= i_spatial * r_r;
            r_pix[4] <= r_pix[3];
        end
    end

    assign o_w = r_w;
    assign o_pix = r_pix[bf3_pkg::LANE_ST-1];
endmodule

/* hdl/bf3_accum.sv */
// Weighted channel products and the registered adder tree over the nine positions.
module bf3_accum #(
    parameter int WFB = 15
) (
    input  logic                                 i_clk,
    input  logic [bf3_pkg::ACC_ST-1:0]           i_en,
    input  logic [bf3_pkg::SPW_W+WFB:0]          i_w   [bf3_pkg::N_LANES],
    input  logic [bf3_pkg::PIX_W-1:0]            i_pix [bf3_pkg::N_LANES],
    output logic [bf3_pkg::SPW_W+WFB+12:0]       o_sum [bf3_pkg::N_CH],
    output logic [bf3_pkg::SPW_W+WFB+4:0]        o_sw,
    output logic [bf3_pkg::PIX_W-1:0]            o_ctr
);
    localparam int W_W  = bf3_pkg::SPW_W + WFB + 1;
    localparam int P_W  = W_W + 8;
    localparam int S_W  = P_W + 4;
    localparam int SW_W = W_W + 4;

    logic [P_W-1:0]  r_p  [bf3_pkg::N_LANES][bf3_pkg::N_CH];
    logic [W_W-1:0]  r_w  [bf3_pkg::N_LANES];
    logic [S_W-1:0]  r_g  [3][bf3_pkg::N_CH];
    logic [SW_W-1:0] r_gw [3];
    logic [S_W-1:0]  r_s  [bf3_pkg::N_CH];
    logic [SW_W-1:0] r_sw;
    logic [bf3_pkg::PIX_W-1:0] r_ctr [bf3_pkg::ACC_ST];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int l = 0; l < bf3_pkg::N_LANES; l++) begin
                for (int c = 0; c < bf3_pkg::N_CH; c++)
                    r_p[l][c] <= i_w[l] * i_pix[l][c*8 +: 8];
                r_w[l] <= i_w[l];
            end
            r_ctr[0] <= i_pix[0];
        end
        if (i_en[1]) begin
            for (int g = 0; g < 3; g++) begin
                for (int c = 0; c < bf3_pkg::N_CH; c++)
                    r_g[g][c] <= S_W'(r_p[3*g][c]) + S_W'(r_p[3*g+1][c])
                               + S_W'(r_p[3*g+2][c]);
                r_gw[g] <= SW_W'(r_w[3*g]) + SW_W'(r_w[3*g+1]) + SW_W'(r_w[3*g+2]);
            end
            r_ctr[1] <= r_ctr[0];
        end
        if (i_en[2]) begin
            for (int c = 0; c < bf3_pkg::N_CH; c++)
                r_s[c] <= r_g[0][c] + r_g[1][c] + r_g[2][c];
            r_sw <= r_gw[0] + r_gw[1] + r_gw[2];
            r_ctr[2] <= r_ctr[1];
        end
    end

    // channel index 0 is blue, 2 is red
    assign o_sum = r_s;
    assign o_sw  = r_sw;
    assign o_ctr = r_ctr[bf3_pkg::ACC_ST-1];
endmodule

/* hdl/bf3_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with zero-weight fallback.
module bf3_div #(
    parameter int WFB = 15
) (
    input  logic                                 i_clk,
    input  logic [bf3_pkg::DIV_ST-1:0]           i_en,
    input  logic [bf3_pkg::SPW_W+WFB+12:0]       i_sum [bf3_pkg::N_CH],
    input  logic [bf3_pkg::SPW_W+WFB+4:0]        i_sw,
    input  logic [bf3_pkg::PIX_W-1:0]            i_ctr,
    output logic [bf3_pkg::CH_W-1:0]             o_q   [bf3_pkg::N_CH]
);
    localparam int S_W  = bf3_pkg::SPW_W + WFB + 13;
    localparam int SW_W = bf3_pkg::SPW_W + WFB + 5;
    localparam int NS   = bf3_pkg::DIV_ST;

    logic [S_W-1:0]            r_rem [NS][bf3_pkg::N_CH];
    logic [bf3_pkg::CH_W-1:0]  r_q   [NS][bf3_pkg::N_CH];
    logic [SW_W-1:0]           r_sw  [NS];
    logic [bf3_pkg::PIX_W-1:0] r_ctr [NS];

    for (genvar j = 0; j < NS; j++) begin : g_st
        localparam int B = NS - 1 - j;
        logic [S_W-1:0]           w_rem [bf3_pkg::N_CH];
        logic [bf3_pkg::CH_W-1:0] w_q   [bf3_pkg::N_CH];
        logic [SW_W-1:0]          w_sw;
        logic [bf3_pkg::PIX_W-1:0] w_ctr;
        logic [S_W-1:0]           w_d;

        if (j == 0) begin : g_in
            assign w_rem = i_sum;
            assign w_sw  = i_sw;
            assign w_ctr = i_ctr;
            for (genvar c = 0; c < bf3_pkg::N_CH; c++) begin : g_z
                assign w_q[c] = '0;
            end
        end else begin : g_prev
            assign w_rem = r_rem[j-1];
            assign w_q   = r_q[j-1];
            assign w_sw  = r_sw[j-1];
            assign w_ctr = r_ctr[j-1];
        end

        assign w_d = {{(S_W-SW_W){1'b0}}, w_sw} << B;

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                for (int c = 0; c < bf3_pkg::N_CH; c++) begin
                    if (w_rem[c] >= w_d) begin
                        r_rem[j][c] <= w_rem[c] - w_d;
                        r_q[j][c]   <= w_q[c] | bf3_pkg::CH_W'(1 << B);
                    end else begin
                        r_rem[j][c] <= w_rem[c];
                        r_q[j][c]   <= w_q[c];
                    end
                end
                r_sw[j]  <= w_sw;
                r_ctr[j] <= w_ctr;
            end
        end
    end

    // weighted mean never exceeds 255, so eight quotient bits suffice
    for (genvar c = 0; c < bf3_pkg::N_CH; c++) begin : g_out
        assign o_q[c] = (r_sw[NS-1] == '0) ? r_ctr[NS-1][c*8 +: 8] : r_q[NS-1][c];
    end
endmodule

/* hdl/bilateral_filter_rgb_3x3_core.sv */
// Throughput: one window per cycle while the output is not stalled; each stage
// holds one word and moves when the stage after it is empty or moving, so stalls
// propagate back without loss.
// Stages: 5 weight-lane, 3 product/adder-tree, 8 divider (one quotient bit each).
// Reset (synchronous, active low) empties the pipeline and loads register defaults.
module bilateral_filter_rgb_3x3_core #(
    parameter int WEIGHT_FRAC_BITS = 15
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bf3_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bf3_pkg::COEF_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [bf3_pkg::PIX_W-1:0]         i_center_pixel,
    input  logic [bf3_pkg::PIX_W-1:0]         i_north_west,
    input  logic [bf3_pkg::PIX_W-1:0]         i_north,
    input  logic [bf3_pkg::PIX_W-1:0]         i_north_east,
    input  logic [bf3_pkg::PIX_W-1:0]         i_west,
    input  logic [bf3_pkg::PIX_W-1:0]         i_east,
    input  logic [bf3_pkg::PIX_W-1:0]         i_south_west,
    input  logic [bf3_pkg::PIX_W-1:0]         i_south,
    input  logic [bf3_pkg::PIX_W-1:0]         i_south_east,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [bf3_pkg::CH_W-1:0]          o_out_red,
    output logic [bf3_pkg::CH_W-1:0]          o_out_green,
    output logic [bf3_pkg::CH_W-1:0]          o_out_blue
);
    localparam int WFB  = WEIGHT_FRAC_BITS;
    localparam int W_W  = bf3_pkg::SPW_W + WFB + 1;
    localparam int S_W  = W_W + 12;
    localparam int SW_W = W_W + 4;
    localparam int NS   = bf3_pkg::N_STAGES;
    localparam int LS   = bf3_pkg::LANE_ST;
    localparam int AS   = bf3_pkg::ACC_ST;

    logic [bf3_pkg::SPW_W-1:0]  r_spw_center, r_spw_edge, r_spw_corner;
    logic [bf3_pkg::COEF_W-1:0] r_coef;
    logic [NS-1:0]              r_v, w_en;

    logic [bf3_pkg::PIX_W-1:0] w_pix  [bf3_pkg::N_LANES];
    logic [bf3_pkg::PIX_W-1:0] w_lpix [bf3_pkg::N_LANES];
    logic [W_W-1:0]            w_w    [bf3_pkg::N_LANES];
    logic [S_W-1:0]            w_sum  [bf3_pkg::N_CH];
    logic [SW_W-1:0]           w_sw;
    logic [bf3_pkg::PIX_W-1:0] w_ctr;
    logic [bf3_pkg::CH_W-1:0]  w_q    [bf3_pkg::N_CH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spw_center <= 16'd32768;
            r_spw_edge   <= 16'd32766;
            r_spw_corner <= 16'd32765;
            r_coef       <= 32'd309818;
        end else if (i_cfg_we) begin
            unique case (bf3_pkg::t_cfg_idx'(i_cfg_idx))
                bf3_pkg::CFG_SPW_CENTER: r_spw_center <= i_cfg_data[15:0];
                bf3_pkg::CFG_SPW_EDGE:   r_spw_edge   <= i_cfg_data[15:0];
                bf3_pkg::CFG_SPW_CORNER: r_spw_corner <= i_cfg_data[15:0];
                bf3_pkg::CFG_RANGE_COEF: r_coef       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a stage moves when it is empty or the next one moves
    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--)
            w_en[k] = !r_v[k] || w_en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0])
                r_v[0] <= i_in_valid;
            for (int k = 1; k < NS; k++)
                if (w_en[k])
                    r_v[k] <= r_v[k-1];
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_v[NS-1];

    assign w_pix[0] = i_center_pixel;
    assign w_pix[1] = i_north_west;
    assign w_pix[2] = i_north;
    assign w_pix[3] = i_north_east;
    assign w_pix[4] = i_west;
    assign w_pix[5] = i_east;
    assign w_pix[6] = i_south_west;
    assign w_pix[7] = i_south;
    assign w_pix[8] = i_south_east;

    for (genvar l = 0; l < bf3_pkg::N_LANES; l++) begin : g_lane
        logic [bf3_pkg::SPW_W-1:0] w_spatial;

        always_comb begin
            case (bf3_pkg::LANE_KIND[l])
                bf3_pkg::POS_CENTER: w_spatial = r_spw_center;
                bf3_pkg::POS_EDGE:   w_spatial = r_spw_edge;
                default:             w_spatial = r_spw_corner;
            endcase
        end

        bf3_lane #(.WFB(WFB)) u_lane (
            .i_clk     (i_clk),
            .i_en      (w_en[LS-1:0]),
            .i_pix     (w_pix[l]),
            .i_ctr     (i_center_pixel),
            .i_coef    (r_coef),
            .i_spatial (w_spatial),
            .o_w       (w_w[l]),
            .o_pix     (w_lpix[l])
        );
    end

    bf3_accum #(.WFB(WFB)) u_accum (
        .i_clk (i_clk),
        .i_en  (w_en[LS+AS-1:LS]),
        .i_w   (w_w),
        .i_pix (w_lpix),
        .o_sum (w_sum),
        .o_sw  (w_sw),
        .o_ctr (w_ctr)
    );

    bf3_div #(.WFB(WFB)) u_div (
        .i_clk (i_clk),
        .i_en  (w_en[NS-1:LS+AS]),
        .i_sum (w_sum),
        .i_sw  (w_sw),
        .i_ctr (w_ctr),
        .o_q   (w_q)
    );

    assign o_out_red   = w_q[2];
    assign o_out_green = w_q[1];
    assign o_out_blue  = w_q[0];
endmodule

/* hdl/bf3_checker.sv */
// Port-level checks for the bilateral filter core, bound to the top level.
module bf3_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [bf3_pkg::CH_W-1:0]      o_out_red,
    input logic [bf3_pkg::CH_W-1:0]      o_out_green,
    input logic [bf3_pkg::CH_W-1:0]      o_out_blue
);
    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // with the output stage empty, nothing can stall the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_out_red) && $stable(o_out_green) && $stable(o_out_blue))
        else $error("result changed while stalled");
endmodule

bind bilateral_filter_rgb_3x3_core bf3_checker u_bf3_checker (.*);

/* tb/sv/bilateral_filter_rgb_3x3_core_tb.sv */
// Self-checking testbench for the 3x3 RGB bilateral filter core.
module bilateral_filter_rgb_3x3_core_tb;

    localparam int WFB         = 15;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 24;

    typedef logic [bf3_pkg::PIX_W-1:0] t_window [bf3_pkg::N_LANES];
    typedef struct packed {
        logic [bf3_pkg::CH_W-1:0] red;
        logic [bf3_pkg::CH_W-1:0] green;
        logic [bf3_pkg::CH_W-1:0] blue;
    } t_rgb;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    bf3_pkg::t_cfg_idx          i_cfg_idx = bf3_pkg::CFG_SPW_CENTER;
    logic [bf3_pkg::COEF_W-1:0] i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [bf3_pkg::PIX_W-1:0]  px [bf3_pkg::N_LANES];
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [bf3_pkg::CH_W-1:0]   o_out_red, o_out_green, o_out_blue;

    initial foreach (px[i]) px[i] = '0;

    bilateral_filter_rgb_3x3_core #(.WEIGHT_FRAC_BITS(WFB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_center_pixel(px[0]), .i_north_west(px[1]), .i_north(px[2]),
        .i_north_east(px[3]), .i_west(px[4]), .i_east(px[5]),
        .i_south_west(px[6]), .i_south(px[7]), .i_south_east(px[8]),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_red(o_out_red), .o_out_green(o_out_green), .o_out_blue(o_out_blue)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // filter settings as the block should hold them
    logic [15:0] sw_center, sw_edge, sw_corner;
    logic [31:0] range_coef;
    logic [32:0] exp_frac [64];

    t_rgb filtered_q [$];
    int   errors = 0;
    int   n_windows = 0;
    int   n_pixels = 0;
    int   n_zero_sum = 0;
    bit   quiet = 1'b0;
    int   cycles = 0;

    function automatic logic [16:0] range_weight(logic [17:0] d2);
        logic [49:0] e;
        logic [32:0] base;
        e = 50'(d2) * 50'(range_coef);
        if (e[49:32] >= bf3_pkg::N_RANGE_MAX) return '0;
        base = exp_frac[e[31:26]] >> (32 - WFB);
        return 17'(base >> e[49:32]);
    endfunction

    function automatic logic [17:0] sq(logic [7:0] a, logic [7:0] b);
        logic [7:0] d;
        d = (a >= b) ? a - b : b - a;
        return 18'(d) * 18'(d);
    endfunction

    function automatic t_rgb filter_window(t_window w, output bit zero_sum);
        logic [63:0] sr, sg, sb, ws, q;
        logic [63:0] wt;
        logic [15:0] sp;
        logic [7:0]  ch [3];
        logic [7:0]  cc [3];
        t_rgb        res;
        sr = 0; sg = 0; sb = 0; ws = 0;
        cc = '{w[0][23:16], w[0][15:8], w[0][7:0]};
        for (int i = 0; i < bf3_pkg::N_LANES; i++) begin
            ch = '{w[i][23:16], w[i][15:8], w[i][7:0]};
            case (bf3_pkg::LANE_KIND[i])
                bf3_pkg::POS_CENTER: sp = sw_center;
                bf3_pkg::POS_EDGE:   sp = sw_edge;
                default:             sp = sw_corner;
            endcase
            wt = 64'(sp) * 64'(range_weight(sq(ch[0], cc[0]) + sq(ch[1], cc[1])
                                             + sq(ch[2], cc[2])));
            sr += wt * ch[0];
            sg += wt * ch[1];
            sb += wt * ch[2];
            ws += wt;
        end
        zero_sum = (ws == 0);
        if (zero_sum) return '{cc[0], cc[1], cc[2]};
        q = sr / ws; res.red   = (q > 255) ? 8'hFF : q[7:0];
        q = sg / ws; res.green = (q > 255) ? 8'hFF : q[7:0];
        q = sb / ws; res.blue  = (q > 255) ? 8'hFF : q[7:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, int expv, int got);
        $display("MISMATCH @%0t pixel %0d %s: expected %0d got %0d",
                 $time, n_pixels, what, expv, got);
        errors++;
    endtask

    // result side: check, then choose next ready with random stall bursts
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (filtered_q.size() == 0) begin
                report_mismatch("unexpected word", 0, 1);
            end else begin
                want = filtered_q.pop_front();
                if (o_out_red !== want.red) report_mismatch("red", want.red, o_out_red);
                if (o_out_green !== want.green)
                    report_mismatch("green", want.green, o_out_green);
                if (o_out_blue !== want.blue) report_mismatch("blue", want.blue, o_out_blue);
            end
            n_pixels++;
        end
        if (!quiet && stall_left == 0 && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 5);
        i_out_ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("bilateral_filter_rgb_3x3_core_tb failed");
            $finish;
        end
    end

    task automatic send_window(t_window w);
        bit zs;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        foreach (px[i]) px[i] <= w[i];
        do @(posedge i_clk); while (!o_in_ready);
        filtered_q.push_back(filter_window(w, zs));
        if (zs) n_zero_sum++;
        n_windows++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // upper data bits beyond a 16-bit register must be dropped
    task automatic write_reg(bf3_pkg::t_cfg_idx idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            bf3_pkg::CFG_SPW_CENTER: sw_center = val[15:0];
            bf3_pkg::CFG_SPW_EDGE:   sw_edge = val[15:0];
            bf3_pkg::CFG_SPW_CORNER: sw_corner = val[15:0];
            default:                 range_coef = val;
        endcase
        @(posedge i_clk);
    endtask

    // settings change only with the pipeline empty
    task automatic set_filter(logic [15:0] c, logic [15:0] e, logic [15:0] k,
                              logic [31:0] rc);
        drain();
        write_reg(bf3_pkg::CFG_SPW_CENTER, {16'($urandom_range(0, 65535)), c});
        write_reg(bf3_pkg::CFG_SPW_EDGE, {16'($urandom_range(0, 65535)), e});
        write_reg(bf3_pkg::CFG_SPW_CORNER, {16'($urandom_range(0, 65535)), k});
        write_reg(bf3_pkg::CFG_RANGE_COEF, rc);
    endtask

    function automatic logic [7:0] near(logic [7:0] c, int spread);
        int v;
        v = int'(c) + $urandom_range(0, 2 * spread) - spread;
        return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
    endfunction

    // mostly textured windows near the centre colour, some noise and image borders
    function automatic t_window random_window();
        t_window w;
        int      mode, spread;
        w[0] = 24'($urandom_range(0, 24'hFFFFFF));
        mode = $urandom_range(0, 9);
        spread = (mode < 3) ? 4 : (mode < 6) ? 40 : 255;
        for (int i = 1; i < bf3_pkg::N_LANES; i++) begin
            w[i] = {near(w[0][23:16], spread), near(w[0][15:8], spread),
                    near(w[0][7:0], spread)};
            if (mode == 9 && $urandom_range(0, 2) == 0) w[i] = '0;
        end
        return w;
    endfunction

    task automatic send_flat(logic [23:0] c, logic [23:0] n);
        t_window w;
        w[0] = c;
        for (int i = 1; i < bf3_pkg::N_LANES; i++) w[i] = n;
        send_window(w);
    endtask

    task automatic test_directed();
        t_window w;
        send_flat(24'h000000, 24'h000000);
        send_flat(24'hFFFFFF, 24'hFFFFFF);
        send_flat(24'hFFFFFF, 24'h000000);
        send_flat(24'h000000, 24'hFFFFFF);
        send_flat(24'h808080, 24'h818080);
        send_flat(24'hFF0000, 24'h00FF00);
        send_flat(24'h0000FF, 24'h0000FE);
        for (int i = 0; i < bf3_pkg::N_LANES; i++) w[i] = 24'h102030 + 24'(i * 24'h030507);
        send_window(w);
        drain();
        // unit range weight everywhere: plain spatial average
        set_filter(16'd32768, 16'd32768, 16'd32768, 32'd0);
        send_flat(24'hFFFFFF, 24'h000000);
        send_flat(24'h123456, 24'hABCDEF);
        // huge coefficient: neighbours keep weight only for very small colour distances
        set_filter(16'd32768, 16'd32766, 16'd32765, 32'hFFFFFFFF);
        send_flat(24'h123456, 24'h123457);
        send_flat(24'h000000, 24'hFFFFFF);
        // zero spatial weights: weight sum is zero, centre passes through
        set_filter(16'd0, 16'd0, 16'd0, 32'd309818);
        send_flat(24'hA5C3E1, 24'h000000);
        send_flat(24'hFFFFFF, 24'hFFFFFF);
        // neighbours only, centre weight zero
        set_filter(16'd0, 16'd65535, 16'd65535, 32'd1000);
        send_flat(24'h404040, 24'hC0C0C0);
        // spatial weights above one
        set_filter(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd309818);
        send_flat(24'h7F7F7F, 24'h807F7E);
        send_flat(24'hFFFFFF, 24'hFEFEFE);
        drain();
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_filter(16'd32768, 16'd32766, 16'd32765, 32'd309818);
                1: set_filter(16'd32768, 16'd32768, 16'd32768, 32'd0);
                2: set_filter(16'd0, 16'd0, 16'd0, $urandom());
                3: set_filter(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
                4: set_filter(16'd32768, 16'd1, 16'd0, $urandom_range(1, 1 << 12));
                default: set_filter(16'($urandom_range(0, 65535)),
                                    16'($urandom_range(0, 65535)),
                                    16'($urandom_range(0, 65535)),
                                    ($urandom_range(0, 3) == 0) ? $urandom()
                                        : $urandom_range(0, 1 << 22));
            endcase
            for (int i = 0; i < 130; i++) begin
                send_window(random_window());
                // hold off once until the pipe is empty
                if (ph == 5 && i == 60) begin
                    i_in_valid <= 1'b0;
                    while (filtered_q.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end
    endtask

    task automatic test_full_rate();
        quiet = 1'b1;
        set_filter(16'd32768, 16'd30000, 16'd25000, 32'd200000);
        for (int i = 0; i < 150; i++) send_window(random_window());
        drain();
    endtask

    initial begin
        logic [95:0] t;
        t = 96'd1 << 32;
        for (int k = 0; k < 64; k++) begin
            exp_frac[k] = t[32:0];
            t = (t * 96'd4248701964) >> 32;
        end
        sw_center = 16'd32768;
        sw_edge = 16'd32766;
        sw_corner = 16'd32765;
        range_coef = 32'd309818;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_settings();
        test_full_rate();
        $display("%0d windows sent, %0d pixels checked, %0d with zero weight sum",
                 n_windows, n_pixels, n_zero_sum);
        $display("covered reset, extreme and random filter settings with stalls");
        if (errors == 0) begin
            $display("bilateral_filter_rgb_3x3_core_tb passed");
        end else begin
            $display("bilateral_filter_rgb_3x3_core_tb failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/bf3_pkg.sv
hdl/bf3_lane.sv
hdl/bf3_accum.sv
hdl/bf3_div.sv
hdl/bilateral_filter_rgb_3x3_core.sv
hdl/bf3_checker.sv
tb/sv/bilateral_filter_rgb_3x3_core_tb.sv
